>>> hw/rtl/fdm_pkg.sv
// fdm_pkg: shared types, constants and the quarter-wave sine table
// for the running dft flux monitor; depends on nothing
package fdm_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_FREQS_DEF  = 16;

  // fixed field widths
  localparam int FIELD_BITS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int TRIG_BITS   = 16;
  localparam int ACC_BITS    = 48;
  localparam int CELL_BITS   = 16;
  localparam int TIME_BITS   = 32;
  localparam int POINT_BITS  = 6;
  localparam int CHAN_BITS   = 4;
  localparam int FLUX_BITS   = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // opcodes
  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_FREQS   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_LENGTH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FREQ_BASE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FREQ_STEP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_WIDTH  = 3'd4;

  // request passed from front to back
  typedef struct packed {
    logic                          op;
    logic [TIME_BITS-1:0]          time_tick;
    logic [POINT_BITS-1:0]         point;
    logic [CHAN_BITS-1:0]          chan;
    logic signed [SAMPLE_BITS-1:0] e_avg;
    logic signed [SAMPLE_BITS-1:0] h_avg;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic signed [FLUX_BITS-1:0] flux;
    logic [CHAN_BITS-1:0]        channel;
  } res_t;

  // one accumulator memory word
  typedef struct packed {
    logic signed [ACC_BITS-1:0] real_e;
    logic signed [ACC_BITS-1:0] imag_e;
    logic signed [ACC_BITS-1:0] real_h;
    logic signed [ACC_BITS-1:0] imag_h;
  } acc_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WORK,
    F_LAST
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ACC,
    B_DRAIN,
    B_RADDR,
    B_RRE,
    B_RIM,
    B_RLAST,
    B_RMUL,
    B_RPUSH
  } back_state_t;

  // quarter-wave sine, q1.15
  localparam logic [14:0] QUARTER_SIN [0:64] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
    15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
    15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
    15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
    15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
    15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
    15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
    15'd32767
  };

  // sine of an 8-bit phase: quadrant in the top two bits
  function automatic logic signed [TRIG_BITS-1:0] sin_of(input logic [7:0] idx);
    logic [6:0]  k;
    logic [15:0] v;
    k = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
    v = {1'b0, QUARTER_SIN[k]};
    return idx[7] ? -$signed(v) : $signed(v);
  endfunction

  // clamp a widened accumulator sum to the signed accumulator range
  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] s);
    logic signed [ACC_BITS-1:0] r;
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      r = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      r = s[ACC_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/fdm_fifo.sv
// fdm_fifo: small register queue with push/full and pop/empty sides
// depends on nothing; used between front and back and on the result side
module fdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  // handshake decode
  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/fdm_front.sv
// fdm_front: accepts input items, averages h and e, keeps the previous e
// samples and queues classified requests; depends on fdm_pkg
module fdm_front #(
  parameter int MAX_POINTS = fdm_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     len_eff,
  input  logic                                clearing,
  input  logic                                push,
  output logic                                full,
  input  logic                                opcode,
  input  logic [fdm_pkg::TIME_BITS-1:0]       time_tick,
  input  logic [fdm_pkg::POINT_BITS-1:0]      point_index,
  input  logic [fdm_pkg::CHAN_BITS-1:0]       freq_index,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_first,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_second,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_third,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_fourth,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] e_here,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] e_next,
  input  logic                                cmd_full,
  output logic                                cmd_push,
  output fdm_pkg::cmd_t                       cmd_data
);

  localparam int SB    = fdm_pkg::SAMPLE_BITS;
  localparam int EW    = $clog2(MAX_POINTS + 1);
  localparam int EDEPTH = MAX_POINTS + 1;

  fdm_pkg::front_state_t state, state_next;

  logic signed [SB-1:0] prev_e [EDEPTH];
  logic                 prev_valid [EDEPTH];

  logic                              op_r;
  logic [fdm_pkg::TIME_BITS-1:0]     time_r;
  logic [fdm_pkg::POINT_BITS-1:0]    point_r;
  logic [fdm_pkg::CHAN_BITS-1:0]     chan_r;
  logic signed [SB-1:0]              h1_r, h2_r, h3_r, h4_r, e0_r, e1_r;
  logic signed [SB-1:0]              pa_r, pb_r;
  logic                              va_r, vb_r;

  logic                 accept;
  logic                 is_read;
  logic                 in_range;
  logic                 is_last;
  logic                 keep;
  logic signed [SB+1:0] h_sum;
  logic signed [SB+1:0] e_sum;
  logic signed [SB-1:0] pa;
  logic signed [SB-1:0] pb;
  logic                 pe_we;
  logic [EW-1:0]        pe_wa;
  logic signed [SB-1:0] pe_wd;

  assign full   = (state != fdm_pkg::F_IDLE) || clearing;
  assign accept = push && !full;

  // classification of the held item
  assign is_read  = (op_r == fdm_pkg::OP_READ);
  assign in_range = (32'(point_r) < 32'(len_eff));
  assign is_last  = ((32'(point_r) + 32'd1) == 32'(len_eff));
  assign keep     = is_read || in_range;

  // field averages, floored
  assign pa    = va_r ? pa_r : '0;
  assign pb    = vb_r ? pb_r : '0;
  assign h_sum = (SB+2)'(h1_r) + (SB+2)'(h2_r) + (SB+2)'(h3_r) + (SB+2)'(h4_r);
  assign e_sum = (SB+2)'(e0_r) + (SB+2)'(e1_r) + (SB+2)'(pa) + (SB+2)'(pb);

  always_comb begin
    cmd_data.op        = op_r;
    cmd_data.time_tick = time_r;
    cmd_data.point     = point_r;
    cmd_data.chan      = chan_r;
    cmd_data.e_avg     = SB'(e_sum >>> 2);
    cmd_data.h_avg     = SB'(h_sum >>> 2);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fdm_pkg::F_IDLE: begin
        if (accept) state_next = fdm_pkg::F_WORK;
      end
      fdm_pkg::F_WORK: begin
        if (!keep) begin
          state_next = fdm_pkg::F_IDLE;
        end else if (!cmd_full) begin
          state_next = (!is_read && is_last) ? fdm_pkg::F_LAST : fdm_pkg::F_IDLE;
        end
      end
      fdm_pkg::F_LAST: state_next = fdm_pkg::F_IDLE;
      default: state_next = fdm_pkg::F_IDLE;
    endcase
  end

  // outputs: queue push and previous e write port
  always_comb begin
    cmd_push = 1'b0;
    pe_we    = 1'b0;
    pe_wa    = EW'(point_r);
    pe_wd    = e0_r;
    unique case (state)
      fdm_pkg::F_WORK: begin
        cmd_push = keep && !cmd_full;
        pe_we    = keep && !cmd_full && !is_read;
      end
      fdm_pkg::F_LAST: begin
        pe_we = 1'b1;
        pe_wa = EW'(point_r) + 1'b1;
        pe_wd = e1_r;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdm_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // valid bits of the previous e store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EDEPTH; i++) prev_valid[i] <= 1'b0;
    end else if (pe_we) begin
      prev_valid[pe_wa] <= 1'b1;
    end
  end

  // previous e store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (pe_we) begin
      prev_e[pe_wa] <= pe_wd;
    end
    if (accept) begin
      pa_r <= prev_e[EW'(point_index)];
      pb_r <= prev_e[EW'(point_index) + 1'b1];
      va_r <= prev_valid[EW'(point_index)];
      vb_r <= prev_valid[EW'(point_index) + 1'b1];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode;
      time_r  <= time_tick;
      point_r <= point_index;
      chan_r  <= freq_index;
      h1_r    <= h_first[SB-1:0];
      h2_r    <= h_second[SB-1:0];
      h3_r    <= h_third[SB-1:0];
      h4_r    <= h_fourth[SB-1:0];
      e0_r    <= e_here[SB-1:0];
      e1_r    <= e_next[SB-1:0];
    end
  end

endmodule

>>> hw/rtl/fdm_back.sv
// fdm_back: carries out queued requests on the accumulator memory:
// dft accumulation per channel and the flux sum; depends on fdm_pkg
module fdm_back #(
  parameter int MAX_POINTS = fdm_pkg::MAX_POINTS_DEF,
  parameter int MAX_FREQS  = fdm_pkg::MAX_FREQS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_FREQS+1)-1:0]    nf_eff,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   len_eff,
  input  logic [31:0]                       freq_base,
  input  logic [31:0]                       freq_step,
  input  logic [fdm_pkg::CELL_BITS-1:0]     cell_width,
  input  logic                              cmd_empty,
  input  fdm_pkg::cmd_t                     cmd_head,
  output logic                              cmd_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output fdm_pkg::res_t                     res_data,
  output logic                              clearing
);

  localparam int SB     = fdm_pkg::SAMPLE_BITS;
  localparam int TB     = fdm_pkg::TRIG_BITS;
  localparam int AB     = fdm_pkg::ACC_BITS;
  localparam int HALF   = AB / 2;
  localparam int PRODW  = SB + TB;
  localparam int FRAC   = TB - 1;
  localparam int DEPTH  = MAX_POINTS * MAX_FREQS;
  localparam int AW     = $clog2(DEPTH);
  localparam int NFW    = $clog2(MAX_FREQS + 1);
  localparam int PW     = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 2 * AB + $clog2(MAX_POINTS) + 2;
  localparam int CHUNKS = 4;
  localparam int CH     = (SUM_W + CHUNKS - 1) / CHUNKS;
  localparam int PADW   = CHUNKS * CH;
  localparam int CWS    = fdm_pkg::CELL_BITS + 1;
  localparam int TW     = CH + 1 + CWS;
  localparam int R_W    = PADW + CWS;
  localparam int FB     = fdm_pkg::FLUX_BITS;

  fdm_pkg::back_state_t state, state_next;

  // accumulator memory
  fdm_pkg::acc_entry_t mem [DEPTH];
  fdm_pkg::acc_entry_t rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  fdm_pkg::acc_entry_t mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  logic [AW-1:0]   clr;

  // held request
  logic [31:0]                   t_r;
  logic [AW-1:0]                 pbase_r;
  logic signed [SB-1:0]          e_r;
  logic signed [SB-1:0]          h_r;
  logic [fdm_pkg::CHAN_BITS-1:0] f_r;

  // accumulate pipeline
  logic [31:0]          fj;
  logic [NFW-1:0]       j;
  logic                 issue;
  logic [AW-1:0]        k_issue;
  logic [31:0]          ph;
  logic                 v1, v2, v3;
  logic [7:0]           s1_idx;
  logic [AW-1:0]        s1_k, s2_k, s3_k;
  logic signed [TB-1:0] s2_sin, s2_cos;
  fdm_pkg::acc_entry_t  s2_acc, s3_acc;
  logic signed [PRODW-1:0] s3_ec, s3_es, s3_hc, s3_hs;
  fdm_pkg::acc_entry_t  s3_new;

  // flux path
  logic [PW-1:0]            i_pt;
  logic [AW-1:0]            rk;
  logic                     pend;
  logic signed [AB-1:0]     op_a, op_b;
  logic signed [HALF-1:0]   a_hi, b_hi;
  logic [HALF-1:0]          a_lo, b_lo;
  logic signed [AB-1:0]     pp_hh;
  logic signed [AB:0]       pp_hl, pp_lh;
  logic [AB-1:0]            pp_ll;
  logic signed [SUM_W-1:0]  c_hh, c_mid, c_ll, comb;
  logic signed [SUM_W-1:0]  sum;
  logic signed [PADW-1:0]   sum_pad;
  logic [CH-1:0]            chunk;
  logic signed [CH:0]       chunk_x;
  logic signed [TW-1:0]     term;
  logic signed [R_W-1:0]    r;
  logic [1:0]               cnt;
  logic signed [R_W-1:0]    rs, rs_hi;
  logic                     fits;
  logic                     chan_ok;
  logic                     j_last;
  logic                     i_last;

  assign chan_ok = (32'(cmd_head.chan) < 32'(nf_eff));
  assign j_last  = ((32'(j) + 32'd1) == 32'(nf_eff));
  assign i_last  = ((32'(i_pt) + 32'd1) == 32'(len_eff));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fdm_pkg::B_CLEAR: begin
        if (clr == AW'(DEPTH - 1)) state_next = fdm_pkg::B_IDLE;
      end
      fdm_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_head.op == fdm_pkg::OP_READ) begin
            state_next = chan_ok ? fdm_pkg::B_RADDR : fdm_pkg::B_RPUSH;
          end else if (nf_eff != '0) begin
            state_next = fdm_pkg::B_ACC;
          end
        end
      end
      fdm_pkg::B_ACC: begin
        if (j_last) state_next = fdm_pkg::B_DRAIN;
      end
      fdm_pkg::B_DRAIN: begin
        if (!v1 && !v2 && !v3) state_next = fdm_pkg::B_IDLE;
      end
      fdm_pkg::B_RADDR: state_next = fdm_pkg::B_RRE;
      fdm_pkg::B_RRE:   state_next = fdm_pkg::B_RIM;
      fdm_pkg::B_RIM:   state_next = i_last ? fdm_pkg::B_RLAST : fdm_pkg::B_RADDR;
      fdm_pkg::B_RLAST: state_next = fdm_pkg::B_RMUL;
      fdm_pkg::B_RMUL: begin
        if (cnt == 2'(CHUNKS - 1)) state_next = fdm_pkg::B_RPUSH;
      end
      fdm_pkg::B_RPUSH: begin
        if (!res_full) state_next = fdm_pkg::B_IDLE;
      end
      default: state_next = fdm_pkg::B_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    clearing = 1'b0;
    issue    = 1'b0;
    unique case (state)
      fdm_pkg::B_CLEAR: clearing = 1'b1;
      fdm_pkg::B_IDLE:  cmd_pop  = !cmd_empty;
      fdm_pkg::B_ACC:   issue    = 1'b1;
      fdm_pkg::B_RPUSH: res_push = !res_full;
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdm_pkg::B_CLEAR;
      clr   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fdm_pkg::B_CLEAR) clr <= clr + 1'b1;
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // memory ports
  assign k_issue = pbase_r + AW'(j);
  assign mem_re  = issue || (state == fdm_pkg::B_RADDR);
  assign mem_ra  = issue ? k_issue : rk;
  assign mem_we  = clearing || v3;
  assign mem_wa  = clearing ? clr : s3_k;
  assign mem_wd  = clearing ? '0 : s3_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // phase of the issued channel
  assign ph = fj * t_r;

  // saturating updates in the last stage
  always_comb begin
    s3_new.real_e = fdm_pkg::sat_acc((AB+1)'(s3_acc.real_e) + (AB+1)'(s3_ec >>> FRAC));
    s3_new.imag_e = fdm_pkg::sat_acc((AB+1)'(s3_acc.imag_e) + (AB+1)'(s3_es >>> FRAC));
    s3_new.real_h = fdm_pkg::sat_acc((AB+1)'(s3_acc.real_h) + (AB+1)'(s3_hc >>> FRAC));
    s3_new.imag_h = fdm_pkg::sat_acc((AB+1)'(s3_acc.imag_h) + (AB+1)'(s3_hs >>> FRAC));
  end

  // partial products of one 48 by 48 product
  assign op_a = (state == fdm_pkg::B_RRE) ? rdata.real_e : rdata.imag_e;
  assign op_b = (state == fdm_pkg::B_RRE) ? rdata.real_h : rdata.imag_h;
  assign a_hi = op_a[AB-1:HALF];
  assign b_hi = op_b[AB-1:HALF];
  assign a_lo = op_a[HALF-1:0];
  assign b_lo = op_b[HALF-1:0];

  // recombine the registered partials
  always_comb begin
    c_hh  = SUM_W'(pp_hh) <<< (2 * HALF);
    c_mid = (SUM_W'(pp_hl) + SUM_W'(pp_lh)) <<< HALF;
    c_ll  = $signed(SUM_W'(pp_ll));
    comb  = c_hh + c_mid + c_ll;
  end

  // scale by cell width, one chunk per cycle from the top
  assign sum_pad = PADW'(sum);
  assign chunk   = sum_pad[(CHUNKS - 1 - 32'(cnt)) * CH +: CH];
  assign chunk_x = (cnt == '0) ? $signed({chunk[CH-1], chunk}) : $signed({1'b0, chunk});
  assign term    = TW'(chunk_x) * TW'($signed({1'b0, cell_width}));

  // floor by 2^8 and saturate
  always_comb begin
    rs    = r >>> 8;
    rs_hi = rs >>> (FB - 1);
    fits  = (rs_hi == '0) || (rs_hi == '1);
    res_data.channel = f_r;
    if (fits) begin
      res_data.flux = rs[FB-1:0];
    end else begin
      res_data.flux = rs[R_W-1] ? {1'b1, {(FB-1){1'b0}}} : {1'b0, {(FB-1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      t_r     <= cmd_head.time_tick;
      pbase_r <= AW'(AW'(cmd_head.point) * AW'(MAX_FREQS));
      e_r     <= cmd_head.e_avg;
      h_r     <= cmd_head.h_avg;
      f_r     <= cmd_head.chan;
      fj      <= freq_base;
      j       <= '0;
      i_pt    <= '0;
      rk      <= AW'(cmd_head.chan);
      pend    <= 1'b0;
      sum     <= '0;
      r       <= '0;
      cnt     <= '0;
    end

    // issue stage
    if (issue) begin
      fj     <= fj + freq_step;
      j      <= j + 1'b1;
      s1_idx <= ph[31:24];
      s1_k   <= k_issue;
    end

    // table stage
    s2_sin <= fdm_pkg::sin_of(s1_idx);
    s2_cos <= fdm_pkg::sin_of(s1_idx + 8'd64);
    s2_acc <= rdata;
    s2_k   <= s1_k;

    // multiply stage
    s3_ec  <= PRODW'(e_r) * PRODW'(s2_cos);
    s3_es  <= PRODW'(e_r) * PRODW'(s2_sin);
    s3_hc  <= PRODW'(h_r) * PRODW'(s2_cos);
    s3_hs  <= PRODW'(h_r) * PRODW'(s2_sin);
    s3_acc <= s2_acc;
    s3_k   <= s2_k;

    // flux sum over points
    if (state == fdm_pkg::B_RRE || state == fdm_pkg::B_RIM) begin
      pp_hh <= AB'(a_hi) * AB'(b_hi);
      pp_hl <= (AB+1)'(a_hi) * $signed({(HALF+1)'(0), b_lo});
      pp_lh <= $signed({(HALF+1)'(0), a_lo}) * (AB+1)'(b_hi);
      pp_ll <= AB'(a_lo) * AB'(b_lo);
    end
    if ((state == fdm_pkg::B_RADDR && pend) || state == fdm_pkg::B_RIM ||
        state == fdm_pkg::B_RLAST) begin
      sum <= sum + comb;
    end
    if (state == fdm_pkg::B_RIM) begin
      pend <= 1'b1;
      i_pt <= i_pt + 1'b1;
      rk   <= rk + AW'(MAX_FREQS);
    end
    if (state == fdm_pkg::B_RMUL) begin
      r   <= (r <<< CH) + R_W'(term);
      cnt <= cnt + 1'b1;
    end
  end

endmodule

>>> hw/rtl/running_dft_flux_monitor.sv
// running_dft_flux_monitor: top level with configuration registers,
// front, request queue, back and result queue; depends on fdm_pkg and all fdm_ modules
//
// usage
// - input side is a queue: drive the item and push; it is taken when full is low.
//   opcode 0 accumulates one point, opcode 1 reads the flux of freq_index.
// - results form a queue: while empty is low the oldest result is on flux_value
//   and flux_channel; pop takes it. only reads give results.
// - configuration: cfg_index/cfg_data taken when cfg_valid is high (cfg_ready is
//   always high); write only while no request is in flight.
// - front: an item passes through F_WORK, and on the last point of the line also
//   F_LAST, since the previous e store has a single write port; full is high meanwhile.
// - back: an accumulate issues one channel per cycle through the issue, table and
//   multiply stages, with a saturating write back into the accumulator memory.
//   a read does one memory read and two 48x48 products split into partials
//   per point, then scales the sum by cell width one chunk at a time.
// - a request queue of 4 entries parts front and back; a result queue of 2
//   entries lets the back keep working while the receiver stalls.
// - after reset the back clears all MAX_POINTS * MAX_FREQS words of the accumulator
//   memory, one word per cycle, with full held high; registers take their
//   reset values at once.
module running_dft_flux_monitor #(
  parameter int MAX_POINTS = fdm_pkg::MAX_POINTS_DEF,
  parameter int MAX_FREQS  = fdm_pkg::MAX_FREQS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  opcode,
  input  logic [fdm_pkg::TIME_BITS-1:0]         time_tick,
  input  logic [fdm_pkg::POINT_BITS-1:0]        point_index,
  input  logic [fdm_pkg::CHAN_BITS-1:0]         freq_index,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_first,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_second,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_third,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] h_fourth,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] e_here,
  input  logic signed [fdm_pkg::FIELD_BITS-1:0] e_next,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [fdm_pkg::FLUX_BITS-1:0]  flux_value,
  output logic [fdm_pkg::CHAN_BITS-1:0]         flux_channel,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fdm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fdm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int NFW = $clog2(MAX_FREQS + 1);
  localparam int PW  = $clog2(MAX_POINTS + 1);

  logic [4:0]  num_freqs;
  logic [6:0]  line_length;
  logic [31:0] freq_base;
  logic [31:0] freq_step;
  logic [fdm_pkg::CELL_BITS-1:0] cell_width;

  logic [NFW-1:0] nf_eff;
  logic [PW-1:0]  len_eff;

  logic          clearing;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  fdm_pkg::cmd_t cmd_wdata, cmd_head;
  logic          res_push, res_full;
  fdm_pkg::res_t res_wdata, res_head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_freqs   <= 5'd1;
      line_length <= 7'd64;
      freq_base   <= '0;
      freq_step   <= '0;
      cell_width  <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdm_pkg::CFG_NUM_FREQS:   num_freqs   <= cfg_data[4:0];
        fdm_pkg::CFG_LINE_LENGTH: line_length <= cfg_data[6:0];
        fdm_pkg::CFG_FREQ_BASE:   freq_base   <= cfg_data;
        fdm_pkg::CFG_FREQ_STEP:   freq_step   <= cfg_data;
        fdm_pkg::CFG_CELL_WIDTH:  cell_width  <= cfg_data[fdm_pkg::CELL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective channel count and line length
  assign nf_eff = (32'(num_freqs) > MAX_FREQS) ? NFW'(MAX_FREQS) : NFW'(num_freqs);

  always_comb begin
    if (line_length == '0) begin
      len_eff = PW'(1);
    end else if (32'(line_length) > MAX_POINTS) begin
      len_eff = PW'(MAX_POINTS);
    end else begin
      len_eff = PW'(line_length);
    end
  end

  fdm_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .len_eff    (len_eff),
    .clearing   (clearing),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .time_tick  (time_tick),
    .point_index(point_index),
    .freq_index (freq_index),
    .h_first    (h_first),
    .h_second   (h_second),
    .h_third    (h_third),
    .h_fourth   (h_fourth),
    .e_here     (e_here),
    .e_next     (e_next),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wdata)
  );

  fdm_fifo #(
    .WIDTH($bits(fdm_pkg::cmd_t)),
    .DEPTH(fdm_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .full (cmd_full),
    .wdata(cmd_wdata),
    .pop  (cmd_pop),
    .empty(cmd_empty),
    .rdata(cmd_head)
  );

  fdm_back #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_FREQS (MAX_FREQS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .nf_eff    (nf_eff),
    .len_eff   (len_eff),
    .freq_base (freq_base),
    .freq_step (freq_step),
    .cell_width(cell_width),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .clearing  (clearing)
  );

  fdm_fifo #(
    .WIDTH($bits(fdm_pkg::res_t)),
    .DEPTH(fdm_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .wdata(res_wdata),
    .pop  (pop),
    .empty(empty),
    .rdata(res_head)
  );

  assign flux_value   = res_head.flux;
  assign flux_channel = res_head.channel;

  // back never takes a request from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_empty))
    else $error("request taken from empty queue");

  // no request is carried out during the clearing pass
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    !(clearing && cmd_pop))
    else $error("request taken during clearing pass");

  // a finished result is never pushed into a full result queue
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into full queue");

endmodule

>>> tb/running_dft_flux_monitor_tb.sv
// running_dft_flux_monitor_tb: self-checking bench for the running dft flux monitor,
// with its own fixed-point predictor of the accumulators and the flux sum
// depends on fdm_pkg and running_dft_flux_monitor
`timescale 1ns / 100ps

module running_dft_flux_monitor_tb;

  localparam int NPTS         = 64;
  localparam int NFRQ         = 16;
  localparam int DRAIN_CYCLES = 3 * NPTS + 8 + NFRQ + 5 + 40;
  localparam int WATCH_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [fdm_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd5;

  // one input request, with an optional hand-typed flux
  typedef struct packed {
    logic                   op;
    logic [31:0]            t;
    logic [5:0]             p;
    logic [3:0]             f;
    logic signed [15:0]     h1, h2, h3, h4, e0, e1;
    logic                   typed;
    logic signed [63:0]     flux;
  } item_t;

  typedef struct packed {
    logic signed [63:0] flux;
    logic [3:0]         chan;
  } flux_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic opcode = fdm_pkg::OP_ACC;
  logic [31:0] time_tick = '0;
  logic [5:0] point_index = '0;
  logic [3:0] freq_index = '0;
  logic signed [15:0] h_first = '0, h_second = '0, h_third = '0, h_fourth = '0;
  logic signed [15:0] e_here = '0, e_next = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [63:0] flux_value;
  logic [3:0] flux_channel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fdm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  running_dft_flux_monitor dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .time_tick(time_tick), .point_index(point_index), .freq_index(freq_index),
    .h_first(h_first), .h_second(h_second), .h_third(h_third), .h_fourth(h_fourth),
    .e_here(e_here), .e_next(e_next), .empty(empty), .pop(pop),
    .flux_value(flux_value), .flux_channel(flux_channel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [4:0]  nf_reg;
  logic [6:0]  len_reg;
  logic [31:0] base_reg, step_reg;
  logic [15:0] cw_reg;
  logic signed [15:0] prev_e [0:NPTS];
  logic signed [47:0] re_e [0:NPTS*NFRQ-1];
  logic signed [47:0] im_e [0:NPTS*NFRQ-1];
  logic signed [47:0] re_h [0:NPTS*NFRQ-1];
  logic signed [47:0] im_h [0:NPTS*NFRQ-1];

  flux_res_t flux_q[$];
  int err_count = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int cfg_writes = 0;
  int sidle = 0, ridle = 0;
  bit hold_req = 0;
  logic [31:0] last_t = '0;

  function automatic int eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > NPTS) return NPTS;
    return int'(len_reg);
  endfunction

  function automatic int eff_nf();
    return (nf_reg > NFRQ) ? NFRQ : int'(nf_reg);
  endfunction

  // table sine with quadrant folding, q1.15
  function automatic logic signed [15:0] table_sine(input logic [7:0] ph);
    logic [6:0] k;
    logic signed [16:0] v;
    k = ph[6] ? (7'd64 - {1'b0, ph[5:0]}) : {1'b0, ph[5:0]};
    v = $signed({2'b00, fdm_pkg::QUARTER_SIN[k]});
    if (ph[7]) v = -v;
    return v[15:0];
  endfunction

  // floored product added into a saturating 48-bit accumulator
  function automatic logic signed [47:0] acc_add(input logic signed [47:0] a,
                                                  input logic signed [31:0] prod);
    logic signed [48:0] s;
    s = 49'(a) + 49'(prod >>> 15);
    if (s[48] != s[47]) return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return s[47:0];
  endfunction

  function automatic logic signed [63:0] flux_of(input int f);
    logic signed [159:0] sum;
    logic signed [159:0] scaled;
    int k;
    sum = '0;
    for (int i = 0; i < eff_len(); i++) begin
      k = i * NFRQ + f;
      sum = sum + 160'(re_e[k]) * 160'(re_h[k]) + 160'(im_e[k]) * 160'(im_h[k]);
    end
    scaled = (sum * $signed({144'b0, cw_reg})) >>> 8;
    if (scaled[159:63] == '0 || scaled[159:63] == '1) return scaled[63:0];
    return scaled[159] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

  // state update for one accepted accumulate request
  task automatic accumulate_point(input item_t it);
    logic signed [17:0] hsum, esum;
    logic signed [15:0] h, e, s, c;
    logic [31:0] fj, ph;
    int p, k;
    p = int'(it.p);
    if (p >= eff_len()) return;
    hsum = 18'(it.h1) + 18'(it.h2) + 18'(it.h3) + 18'(it.h4);
    esum = 18'(it.e0) + 18'(it.e1) + 18'(prev_e[p]) + 18'(prev_e[p+1]);
    h = 16'(hsum >>> 2);
    e = 16'(esum >>> 2);
    prev_e[p] = it.e0;
    if (p == eff_len() - 1) prev_e[p+1] = it.e1;
    for (int j = 0; j < eff_nf(); j++) begin
      fj = base_reg + 32'(j) * step_reg;
      ph = fj * it.t;
      s = table_sine(ph[31:24]);
      c = table_sine(ph[31:24] + 8'd64);
      k = p * NFRQ + j;
      re_e[k] = acc_add(re_e[k], e * c);
      im_e[k] = acc_add(im_e[k], e * s);
      re_h[k] = acc_add(re_h[k], h * c);
      im_h[k] = acc_add(im_h[k], h * s);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // hand one request to the block and predict on acceptance
  task automatic send_item(input item_t it);
    bit taken;
    flux_res_t r;
    while ($urandom_range(99) < sidle) begin
      push = 1'b0;
      @(negedge clk);
    end
    opcode = it.op; time_tick = it.t; point_index = it.p; freq_index = it.f;
    h_first = it.h1; h_second = it.h2; h_third = it.h3; h_fourth = it.h4;
    e_here = it.e0; e_next = it.e1;
    push = 1'b1;
    do begin
      @(posedge clk);
      taken = !full;
      if (taken) begin
        items_sent++;
        if (it.op == fdm_pkg::OP_READ) begin
          r.chan = it.f;
          if (it.typed) r.flux = it.flux;
          else r.flux = (int'(it.f) < eff_nf()) ? flux_of(int'(it.f)) : '0;
          flux_q.push_back(r);
        end else begin
          accumulate_point(it);
        end
      end
      @(negedge clk);
    end while (!taken);
  endtask

  // wait for all flux results, then for the back to finish silent work
  task automatic settle();
    push = 1'b0;
    while (flux_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [fdm_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_index = idx; cfg_data = data; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      fdm_pkg::CFG_NUM_FREQS:   nf_reg   = data[4:0];
      fdm_pkg::CFG_LINE_LENGTH: len_reg  = data[6:0];
      fdm_pkg::CFG_FREQ_BASE:   base_reg = data;
      fdm_pkg::CFG_FREQ_STEP:   step_reg = data;
      fdm_pkg::CFG_CELL_WIDTH:  cw_reg   = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] nf, input logic [31:0] len,
                            input logic [31:0] base, input logic [31:0] step,
                            input logic [31:0] cw);
    settle();
    cfg_write(fdm_pkg::CFG_NUM_FREQS, nf);
    cfg_write(fdm_pkg::CFG_LINE_LENGTH, len);
    cfg_write(fdm_pkg::CFG_FREQ_BASE, base);
    cfg_write(fdm_pkg::CFG_FREQ_STEP, step);
    cfg_write(fdm_pkg::CFG_CELL_WIDTH, cw);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'sh7FFF;
    if (r < 20) return 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int r;
    it.op = ($urandom_range(99) < 20) ? fdm_pkg::OP_READ : fdm_pkg::OP_ACC;
    it.p = ($urandom_range(99) < 85) ? 6'($urandom_range(eff_len() - 1)) : 6'($urandom);
    if ($urandom_range(99) < 80 && eff_nf() > 0) it.f = 4'($urandom_range(eff_nf() - 1));
    else it.f = 4'($urandom);
    r = $urandom_range(99);
    it.t = (r < 10) ? 32'd0 : (r < 20) ? last_t : $urandom;
    last_t = it.t;
    it.h1 = rand_sample(); it.h2 = rand_sample(); it.h3 = rand_sample();
    it.h4 = rand_sample(); it.e0 = rand_sample(); it.e1 = rand_sample();
    it.typed = 1'b0;
    it.flux = '0;
    return it;
  endfunction

  // directed requests at the reset configuration: one channel, phase always zero
  item_t dir_rows [12] = '{
    '{fdm_pkg::OP_READ, 32'd0, 6'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b1, 64'sd0},
    '{fdm_pkg::OP_READ, 32'd7, 6'd0, 4'd15, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b1, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'd0, 6'd0, 4'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
      16'sh7FFF, 16'sh7FFF, 1'b0, 64'sd0},
    '{fdm_pkg::OP_READ, 32'd0, 6'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b0, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'hFFFFFFFF, 6'd63, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000,
      16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'hFFFFFFFF, 6'd62, 4'd0, 16'sh8000, 16'sh7FFF, 16'sh0001,
      16'shFFFF, 16'sh1234, 16'shEDCB, 1'b0, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'd5, 6'd0, 4'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
      16'sh8000, 16'sh7FFF, 1'b0, 64'sd0},
    '{fdm_pkg::OP_READ, 32'd0, 6'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b0, 64'sd0},
    '{fdm_pkg::OP_READ, 32'd0, 6'd0, 4'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b1, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'd5, 6'd63, 4'd9, 16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0,
      16'sh5555, 16'shAAAA, 1'b0, 64'sd0},
    '{fdm_pkg::OP_ACC, 32'd5, 6'd63, 4'd0, 16'shAAAA, 16'sh5555, 16'shF0F0, 16'sh0F0F,
      16'shAAAA, 16'sh5555, 1'b0, 64'sd0},
    '{fdm_pkg::OP_READ, 32'd0, 6'd0, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 1'b0, 64'sd0}
  };

  // random phase with the idling mode chosen by the caller
  task automatic run_phase(input int s_pct, input int r_pct, input bit with_hold);
    sidle = s_pct;
    ridle = r_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == 40) hold_req = 1;
      send_item(rand_item());
    end
  endtask

  // result side: random pops, one long hold-off, compare with the oldest flux
  initial begin
    int hold_left;
    flux_res_t want;
    hold_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= ridle);
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (flux_q.size() == 0) begin
          report("unexpected result", flux_value, '0);
        end else begin
          want = flux_q.pop_front();
          reads_checked++;
          if (flux_value !== want.flux) report("flux_value", flux_value, want.flux);
          if (flux_channel !== want.chan) report("flux_channel", flux_channel, want.chan);
        end
      end
    end
  end

  // watchdog on cycles with no accepted request, result pop or register write
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    nf_reg = 5'd1; len_reg = 7'd64; base_reg = '0; step_reg = '0; cw_reg = 16'd256;
    for (int i = 0; i <= NPTS; i++) prev_e[i] = '0;
    for (int i = 0; i < NPTS * NFRQ; i++) begin
      re_e[i] = '0; im_e[i] = '0; re_h[i] = '0; im_h[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    sidle = 34;
    ridle = 64;
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    set_config(32'd16, 32'd64, $urandom, $urandom, 32'hFFFF);
    run_phase(34, 64, 1'b1);
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_phase(34, 64, 1'b0);
    set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
    cfg_write(CFG_UNUSED, $urandom);
    run_phase(64, 34, 1'b0);
    set_config($urandom_range(16, 1), $urandom_range(16, 1), $urandom, $urandom,
               $urandom);
    run_phase(64, 34, 1'b0);
    set_config(32'd3, 32'd5, 32'h00800000, 32'h00100000, 32'd256);
    run_phase(0, 0, 1'b0);

    settle();
    if (flux_q.size() != 0) report("results left over", flux_q.size(), '0);
    $display("covered %0d requests, %0d flux reads and %0d register writes",
             items_sent, reads_checked, cfg_writes);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
